// ===== rtl/core/rvdec_pkg.sv =====
package rvdec_pkg;

  // Major opcodes, instr[6:0]
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  // SYSTEM immediates
  localparam logic [11:0] SYS_ECALL  = 12'd0;
  localparam logic [11:0] SYS_EBREAK = 12'd1;

  // Format classes
  localparam logic [2:0] FMT_I   = 3'd0;
  localparam logic [2:0] FMT_R   = 3'd1;
  localparam logic [2:0] FMT_S   = 3'd2;
  localparam logic [2:0] FMT_U   = 3'd3;
  localparam logic [2:0] FMT_B   = 3'd4;
  localparam logic [2:0] FMT_J   = 3'd5;
  localparam logic [2:0] FMT_UNK = 3'd6;

  // Dense operation numbers
  localparam logic [5:0] OP_LUI    = 6'd0;
  localparam logic [5:0] OP_AUIPC  = 6'd1;
  localparam logic [5:0] OP_JAL    = 6'd2;
  localparam logic [5:0] OP_JALR   = 6'd3;
  localparam logic [5:0] OP_BEQ    = 6'd4;
  localparam logic [5:0] OP_BNE    = 6'd5;
  localparam logic [5:0] OP_BLT    = 6'd6;
  localparam logic [5:0] OP_BGE    = 6'd7;
  localparam logic [5:0] OP_BLTU   = 6'd8;
  localparam logic [5:0] OP_BGEU   = 6'd9;
  localparam logic [5:0] OP_LB     = 6'd10;
  localparam logic [5:0] OP_LH     = 6'd11;
  localparam logic [5:0] OP_LW     = 6'd12;
  localparam logic [5:0] OP_LBU    = 6'd13;
  localparam logic [5:0] OP_LHU    = 6'd14;
  localparam logic [5:0] OP_SB     = 6'd15;
  localparam logic [5:0] OP_SH     = 6'd16;
  localparam logic [5:0] OP_SW     = 6'd17;
  localparam logic [5:0] OP_ADDI   = 6'd18;
  localparam logic [5:0] OP_SLTI   = 6'd19;
  localparam logic [5:0] OP_SLTIU  = 6'd20;
  localparam logic [5:0] OP_XORI   = 6'd21;
  localparam logic [5:0] OP_ORI    = 6'd22;
  localparam logic [5:0] OP_ANDI   = 6'd23;
  localparam logic [5:0] OP_SLLI   = 6'd24;
  localparam logic [5:0] OP_SRLI   = 6'd25;
  localparam logic [5:0] OP_SRAI   = 6'd26;
  localparam logic [5:0] OP_ADD    = 6'd27;
  localparam logic [5:0] OP_SUB    = 6'd28;
  localparam logic [5:0] OP_SLL    = 6'd29;
  localparam logic [5:0] OP_SLT    = 6'd30;
  localparam logic [5:0] OP_SLTU   = 6'd31;
  localparam logic [5:0] OP_XOR    = 6'd32;
  localparam logic [5:0] OP_SRL    = 6'd33;
  localparam logic [5:0] OP_SRA    = 6'd34;
  localparam logic [5:0] OP_OR     = 6'd35;
  localparam logic [5:0] OP_AND    = 6'd36;
  localparam logic [5:0] OP_ECALL  = 6'd37;
  localparam logic [5:0] OP_EBREAK = 6'd38;
  localparam logic [5:0] OP_SYSNOP = 6'd39;

  typedef struct packed {
    logic [2:0]         format_class;
    logic [5:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic               illegal;
  } dec_t;

endpackage

// ===== rtl/core/rvdec_if.sv =====
interface rvdec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface rvdec_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         format_class;
  logic [5:0]         operation;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  logic               illegal;

  modport source (output valid, output format_class, output operation, output dest_reg,
                  output src1_reg, output src2_reg, output immediate, output illegal,
                  input ready);
  modport sink   (input valid, input format_class, input operation, input dest_reg,
                  input src1_reg, input src2_reg, input immediate, input illegal,
                  output ready);
endinterface

// ===== rtl/core/rvdec_decode.sv =====
module rvdec_decode
  import rvdec_pkg::*;
(
  input  logic [31:0] word,
  output dec_t        dec
);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] iimm;
  logic [5:0]  op;
  logic        bad;

  assign opc  = word[6:0];
  assign rd   = word[11:7];
  assign f3   = word[14:12];
  assign rs1  = word[19:15];
  assign rs2  = word[24:20];
  assign f7   = word[31:25];
  assign iimm = {{20{word[31]}}, word[31:20]};

  always_comb begin
    dec.format_class = FMT_UNK;
    dec.dest_reg     = 5'd0;
    dec.src1_reg     = 5'd0;
    dec.src2_reg     = 5'd0;
    dec.immediate    = 32'sd0;
    op               = OP_LUI;
    bad              = 1'b0;

    case (opc)
      OPC_LOAD: begin
        dec.format_class = FMT_I;
        dec.dest_reg     = rd;
        dec.src1_reg     = rs1;
        dec.immediate    = iimm;
        case (f3)
          F3_0:    op = OP_LB;
          F3_1:    op = OP_LH;
          F3_2:    op = OP_LW;
          F3_4:    op = OP_LBU;
          F3_5:    op = OP_LHU;
          default: bad = 1'b1;
        endcase
      end
      OPC_OPIMM: begin
        dec.format_class = FMT_I;
        dec.dest_reg     = rd;
        dec.src1_reg     = rs1;
        dec.immediate    = iimm;
        case (f3)
          F3_0: op = OP_ADDI;
          F3_2: op = OP_SLTI;
          F3_3: op = OP_SLTIU;
          F3_4: op = OP_XORI;
          F3_6: op = OP_ORI;
          F3_7: op = OP_ANDI;
          F3_1: begin
            // shift amount, zero-extended
            dec.immediate = {27'd0, rs2};
            if (f7 == F7_ZERO) op = OP_SLLI;
            else               bad = 1'b1;
          end
          default: begin
            dec.immediate = {27'd0, rs2};
            if (f7 == F7_ZERO)     op = OP_SRLI;
            else if (f7 == F7_ALT) op = OP_SRAI;
            else                   bad = 1'b1;
          end
        endcase
      end
      OPC_JALR: begin
        dec.format_class = FMT_I;
        dec.dest_reg     = rd;
        dec.src1_reg     = rs1;
        dec.immediate    = iimm;
        if (f3 == F3_0) op = OP_JALR;
        else            bad = 1'b1;
      end
      OPC_SYSTEM: begin
        dec.format_class = FMT_I;
        dec.dest_reg     = rd;
        dec.src1_reg     = rs1;
        dec.immediate    = iimm;
        if (word[31:20] == SYS_ECALL)       op = OP_ECALL;
        else if (word[31:20] == SYS_EBREAK) op = OP_EBREAK;
        else                                op = OP_SYSNOP;
      end
      OPC_OP: begin
        dec.format_class = FMT_R;
        dec.dest_reg     = rd;
        dec.src1_reg     = rs1;
        dec.src2_reg     = rs2;
        if (f7 == F7_ZERO) begin
          case (f3)
            F3_0:    op = OP_ADD;
            F3_1:    op = OP_SLL;
            F3_2:    op = OP_SLT;
            F3_3:    op = OP_SLTU;
            F3_4:    op = OP_XOR;
            F3_5:    op = OP_SRL;
            F3_6:    op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_0) begin
          op = OP_SUB;
        end else if (f7 == F7_ALT && f3 == F3_5) begin
          op = OP_SRA;
        end else begin
          bad = 1'b1;
        end
      end
      OPC_STORE: begin
        dec.format_class = FMT_S;
        dec.src1_reg     = rs1;
        dec.src2_reg     = rs2;
        dec.immediate    = {{20{word[31]}}, word[31:25], word[11:7]};
        case (f3)
          F3_0:    op = OP_SB;
          F3_1:    op = OP_SH;
          F3_2:    op = OP_SW;
          default: bad = 1'b1;
        endcase
      end
      OPC_LUI, OPC_AUIPC: begin
        dec.format_class = FMT_U;
        dec.dest_reg     = rd;
        dec.immediate    = {word[31:12], 12'd0};
        op               = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
      end
      OPC_BRANCH: begin
        dec.format_class = FMT_B;
        dec.src1_reg     = rs1;
        dec.src2_reg     = rs2;
        dec.immediate    = {{19{word[31]}}, word[31], word[7], word[30:25],
                            word[11:8], 1'b0};
        case (f3)
          F3_0:    op = OP_BEQ;
          F3_1:    op = OP_BNE;
          F3_4:    op = OP_BLT;
          F3_5:    op = OP_BGE;
          F3_6:    op = OP_BLTU;
          F3_7:    op = OP_BGEU;
          default: bad = 1'b1;
        endcase
      end
      OPC_JAL: begin
        dec.format_class = FMT_J;
        dec.dest_reg     = rd;
        dec.immediate    = {{11{word[31]}}, word[31], word[19:12], word[20],
                            word[30:21], 1'b0};
        op               = OP_JAL;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // drop the operation number on an illegal word
    dec.operation = bad ? OP_LUI : op;
    dec.illegal   = bad;
  end

endmodule

// ===== rtl/core/rv32i_instruction_decoder_top.sv =====
// Channel   Modport  Word contents
// --------  -------  ---------------------------------------------------------
// in_chan   sink     instruction[31:0]
// out_chan  source   format_class, operation, dest_reg, src1_reg, src2_reg,
//                    immediate (signed), illegal
//
// On acceptance the word is captured in an input register, decoded by one
// level of combinational logic and held in the result register. One word is
// accepted every cycle while results drain.
// rst_n (synchronous, active low) empties both stages; payload is not reset.
// A stall on out_chan holds the result register and back-pressures the input
// stage through the ready chain; nothing is dropped or repeated.
module rv32i_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rvdec_in_if.sink    in_chan,
  rvdec_out_if.source out_chan
);

  // Input stage
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_word_r;
  logic        s1_ready;

  // Result stage
  logic        s2_valid_r;
  logic        s2_valid_nxt;
  dec_t        s2_dec_r;
  logic        s2_ready;

  dec_t        dec;

  // A stage takes a new word when it is empty or its contents move on
  assign s2_ready       = !s2_valid_r || out_chan.ready;
  assign s1_ready       = !s1_valid_r || s2_ready;
  assign in_chan.ready  = s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) s1_valid_nxt = in_chan.valid;
    s2_valid_nxt = s2_valid_r;
    if (s2_ready) s2_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) s1_word_r <= in_chan.instruction;
  end

  rvdec_decode u_decode (
    .word (s1_word_r),
    .dec  (dec)
  );

  // Advance the decoded word into the result register
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) s2_dec_r <= dec;
  end

  assign out_chan.valid        = s2_valid_r;
  assign out_chan.format_class = s2_dec_r.format_class;
  assign out_chan.operation    = s2_dec_r.operation;
  assign out_chan.dest_reg     = s2_dec_r.dest_reg;
  assign out_chan.src1_reg     = s2_dec_r.src1_reg;
  assign out_chan.src2_reg     = s2_dec_r.src2_reg;
  assign out_chan.immediate    = s2_dec_r.immediate;
  assign out_chan.illegal      = s2_dec_r.illegal;

endmodule
